@@ rtl/pru_pkg.sv @@
// Package for the palette register unit: transaction structs, command,
// port and table codes, reset values and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pru_pkg;

    // Input transaction
    typedef struct packed {
        logic [1:0] command;
        logic [2:0] port;
        logic [7:0] write_data;
        logic [2:0] lookup_table;
        logic [2:0] lookup_palette;
        logic [1:0] lookup_color;
    } t_item;

    // Result transaction
    typedef struct packed {
        logic [7:0] read_data;
        logic [4:0] red;
        logic [4:0] green;
        logic [4:0] blue;
    } t_result;

    // Commands
    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    // Byte ports
    localparam logic [2:0] PORT_BG_MONO   = 3'd0;
    localparam logic [2:0] PORT_OBJ0_MONO = 3'd1;
    localparam logic [2:0] PORT_OBJ1_MONO = 3'd2;
    localparam logic [2:0] PORT_BG_INDEX  = 3'd3;
    localparam logic [2:0] PORT_BG_DATA   = 3'd4;
    localparam logic [2:0] PORT_OBJ_INDEX = 3'd5;
    localparam logic [2:0] PORT_OBJ_DATA  = 3'd6;
    localparam int         PORT_COUNT     = 7;
    localparam int         MONO_COUNT     = 3;

    // Lookup tables
    localparam logic [2:0] TABLE_BG_COLOUR  = 3'd3;
    localparam logic [2:0] TABLE_OBJ_COLOUR = 3'd4;

    // Configuration register indexes
    localparam int         CFG_IDX_W = 2;
    localparam int         GRAY_W    = 5;
    localparam logic [GRAY_W-1:0] GRAY_RESET_0 = 5'd31;
    localparam logic [GRAY_W-1:0] GRAY_RESET_1 = 5'd16;
    localparam logic [GRAY_W-1:0] GRAY_RESET_2 = 5'd8;
    localparam logic [GRAY_W-1:0] GRAY_RESET_3 = 5'd0;

    localparam logic [7:0] MONO_RESET = 8'hE4;

    // Index byte layout
    localparam int INDEX_AUTO_INC_BIT = 7;

    localparam int COLOUR_W          = 15;
    localparam int PALETTE_COUNT_DEF = 8;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

`default_nettype wire

@@ rtl/pru_colour_ram.sv @@
// Colour palette RAM: one write port, one read port with registered data.
// Per-entry valid bits cleared by reset make unwritten entries read as zero.
// Depends on pru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pru_colour_ram
    import pru_pkg::*;
#(
    parameter int ADDR_W = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_rd_en,
    input  wire logic [ADDR_W-1:0]   i_rd_addr,
    output      logic [COLOUR_W-1:0] o_rd_data,
    input  wire logic                i_wr_en,
    input  wire logic [ADDR_W-1:0]   i_wr_addr,
    input  wire logic [COLOUR_W-1:0] i_wr_data
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [COLOUR_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]    r_valid;
    logic [COLOUR_W-1:0] r_rd_data;
    logic                r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

@@ rtl/palette_register_unit_core.sv @@
// Top level of the palette register unit: command sequencer, byte port and
// gray level registers, result register. Depends on pru_pkg, pru_colour_ram.
`timescale 1ns / 1ps
`default_nettype none

// A command is taken when i_start is high and o_busy is low. The accept edge
// launches the colour RAM read, the next cycle executes the command (o_busy
// is high then; a data port write does its read-modify-write there), and the
// result sits on o_result for exactly one cycle with o_done high, in the same
// cycle in which the next command may be accepted; no command is taken while
// one executes. Every command gives exactly one result; the receiver cannot
// stall it. Reset clears the colour RAM at once through per-entry valid bits,
// so no clearing pass is needed. The user must write gray levels through
// i_cfg_we / i_cfg_idx / i_cfg_data only while idle; the block does not enforce this.
module palette_register_unit_core
    import pru_pkg::*;
#(
    parameter int PALETTE_COUNT = PALETTE_COUNT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output      logic                 o_busy,
    input  wire t_item                i_item,
    output      logic                 o_done,
    output      t_result              o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [GRAY_W-1:0]    i_cfg_data
);

    localparam int PAL_W  = (PALETTE_COUNT > 1) ? $clog2(PALETTE_COUNT) : 1;
    localparam int ADDR_W = 1 + PAL_W + 2;
    localparam logic [3:0] PAL_LIMIT = 4'(PALETTE_COUNT);

    t_state r_state, n_state;
    t_item  r_item;
    logic [ADDR_W-1:0] r_ram_addr;

    logic [7:0]        r_port_bytes [PORT_COUNT];
    logic [7:0]        n_port_bytes [PORT_COUNT];
    logic [7:0]        r_mono [MONO_COUNT];
    logic [7:0]        n_mono [MONO_COUNT];
    logic [GRAY_W-1:0] r_gray [4];

    t_result r_result, n_result;
    logic    r_done;

    logic accept;
    logic exec;

    // RAM address formed at accept
    logic              acc_sel;
    logic [2:0]        acc_pal;
    logic [1:0]        acc_col;
    logic [7:0]        acc_index;
    logic [ADDR_W-1:0] rd_addr;

    // Exec cycle
    logic [COLOUR_W-1:0] ram_word;
    logic                ram_we;
    logic [COLOUR_W-1:0] ram_wdata;
    logic [7:0]          ex_index;
    logic [2:0]          ex_index_port;
    logic [1:0]          shade;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_start) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy = 1'b0;
        exec   = 1'b0;
        unique case (r_state)
            ST_IDLE: o_busy = 1'b0;
            ST_EXEC: begin
                o_busy = 1'b1;
                exec   = 1'b1;
            end
            default: o_busy = 1'b0;
        endcase
    end

    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- read launch ----------------
    always_comb begin
        acc_index = (i_item.port == PORT_OBJ_DATA) ? r_port_bytes[PORT_OBJ_INDEX]
                                                   : r_port_bytes[PORT_BG_INDEX];
        if (i_item.command == CMD_LOOKUP) begin
            acc_sel = (i_item.lookup_table == TABLE_OBJ_COLOUR);
            acc_pal = i_item.lookup_palette;
            acc_col = i_item.lookup_color;
        end else begin
            acc_sel = (i_item.port == PORT_OBJ_DATA);
            acc_pal = acc_index[5:3];
            acc_col = acc_index[2:1];
        end
        rd_addr = {acc_sel, acc_pal[PAL_W-1:0], acc_col};
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item     <= i_item;
            r_ram_addr <= rd_addr;
        end
    end

    pru_colour_ram #(
        .ADDR_W (ADDR_W)
    ) u_colour_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_word),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_ram_addr),
        .i_wr_data (ram_wdata)
    );

    // ---------------- execute ----------------
    always_comb begin
        n_port_bytes  = r_port_bytes;
        n_mono        = r_mono;
        n_result      = '0;
        ram_we        = 1'b0;
        ram_wdata     = ram_word;
        ex_index_port = (r_item.port == PORT_OBJ_DATA) ? PORT_OBJ_INDEX : PORT_BG_INDEX;
        ex_index      = r_port_bytes[ex_index_port];
        shade         = 2'd0;

        if (exec) begin
            unique case (r_item.command)
                CMD_READ: begin
                    if (r_item.port < 3'(PORT_COUNT)) begin
                        n_result.read_data = r_port_bytes[r_item.port];
                    end
                end
                CMD_WRITE: begin
                    if (r_item.port < 3'(PORT_COUNT)) begin
                        n_port_bytes[r_item.port] = r_item.write_data;
                    end
                    case (r_item.port) inside
                        PORT_BG_MONO, PORT_OBJ0_MONO, PORT_OBJ1_MONO: begin
                            n_mono[r_item.port[1:0]] = r_item.write_data;
                        end
                        PORT_BG_DATA, PORT_OBJ_DATA: begin
                            ram_we = ({1'b0, ex_index[5:3]} < PAL_LIMIT);
                            if (!ex_index[0]) begin
                                ram_wdata = {ram_word[14:8], r_item.write_data};
                            end else begin
                                ram_wdata = {r_item.write_data[6:0], ram_word[7:0]};
                            end
                            if (ex_index[INDEX_AUTO_INC_BIT]) begin
                                n_port_bytes[ex_index_port] =
                                    {ex_index[7:6], ex_index[5:0] + 6'd1};
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_LOOKUP: begin
                    if (r_item.lookup_table < 3'(MONO_COUNT)) begin
                        shade = r_mono[r_item.lookup_table[1:0]][2*r_item.lookup_color +: 2];
                        n_result.red   = r_gray[shade];
                        n_result.green = r_gray[shade];
                        n_result.blue  = r_gray[shade];
                    end else if ((r_item.lookup_table == TABLE_BG_COLOUR
                                  || r_item.lookup_table == TABLE_OBJ_COLOUR)
                                 && ({1'b0, r_item.lookup_palette} < PAL_LIMIT)) begin
                        n_result.red   = ram_word[4:0];
                        n_result.green = ram_word[9:5];
                        n_result.blue  = ram_word[14:10];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PORT_COUNT; i++) r_port_bytes[i] <= '0;
            for (int i = 0; i < MONO_COUNT; i++) r_mono[i] <= MONO_RESET;
            r_gray[0] <= GRAY_RESET_0;
            r_gray[1] <= GRAY_RESET_1;
            r_gray[2] <= GRAY_RESET_2;
            r_gray[3] <= GRAY_RESET_3;
            r_done    <= 1'b0;
        end else begin
            r_port_bytes <= n_port_bytes;
            r_mono       <= n_mono;
            if (i_cfg_we) begin
                r_gray[i_cfg_idx] <= i_cfg_data;
            end
            r_done <= exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_done ? r_result : '0;

    // ---------------- assertions ----------------
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == ST_EXEC))
        else $error("result strobe without an executed transaction");

    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> (r_state == ST_IDLE) && o_done)
        else $error("execute cycle did not complete in one cycle");

    a_ram_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> exec && (r_item.command == CMD_WRITE))
        else $error("colour RAM written outside a data write");

    a_no_colour_on_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && (r_item.command != CMD_LOOKUP) |=>
            (o_result.red == '0) && (o_result.green == '0) && (o_result.blue == '0))
        else $error("colour fields set on a register access");

    a_no_read_data_on_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && (r_item.command != CMD_READ) |=> (o_result.read_data == '0))
        else $error("read data set on a non-read transaction");

endmodule

`default_nettype wire
